FILE: src/sbcmk_pkg.sv
// Shared types and constants for the sprite blitter.
// Item structs, config register set, request and register codes.
// No dependencies.
package sbcmk_pkg;

  // Parameter defaults
  localparam int DEF_SCREEN_WIDTH    = 320;
  localparam int DEF_SCREEN_HEIGHT   = 240;
  localparam int DEF_MAX_SPRITE_SIZE = 1024;
  localparam int DEF_PALETTE_SIZE    = 256;
  localparam int DEF_KEY_INDEX       = 0;

  // Field widths
  localparam int REQ_W      = 2;
  localparam int FRAME_W    = 16;
  localparam int SRC_W      = 10;
  localparam int VALUE_W    = 16;
  localparam int SLOT_W     = 8;
  localparam int ADDR_W     = 17;
  localparam int COLOR_W    = 16;
  localparam int CNT_W      = 32;
  localparam int POS_W      = 16;
  localparam int SIZE_W     = 11;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  // screen coordinates are below 4096 for every legal screen size
  localparam int COORD_W    = 12;

  // mode_bits positions
  localparam int MODE_INDEXED = 0;
  localparam int MODE_KEY     = 1;
  localparam int MODE_MIRROR  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PIXEL   = 2'd0,
    REQ_PALETTE = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_NOP     = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X         = 3'd0,
    CFG_POS_Y         = 3'd1,
    CFG_SPRITE_WIDTH  = 3'd2,
    CFG_SPRITE_HEIGHT = 3'd3,
    CFG_MODE_BITS     = 3'd4,
    CFG_KEY_COLOR     = 3'd5,
    CFG_FRAME_SELECT  = 3'd6,
    CFG_FRAME_TOTAL   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [FRAME_W-1:0] frame_num;
    logic [SRC_W-1:0]   src_row;
    logic [SRC_W-1:0]   src_col;
    logic [VALUE_W-1:0] pixel_value;
    logic [SLOT_W-1:0]  palette_slot;
  } in_item_t;

  typedef struct packed {
    logic               write_enable;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic [CNT_W-1:0]   opaque_count;
    logic [CNT_W-1:0]   keyed_count;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [SIZE_W-1:0]       sprite_width;
    logic [SIZE_W-1:0]       sprite_height;
    logic [MODE_W-1:0]       mode_bits;
    logic [COLOR_W-1:0]      key_color;
    logic [FRAME_W-1:0]      frame_select;
    logic [FRAME_W-1:0]      frame_total;
  } cfg_t;

  // Front-end decision for one item
  typedef struct packed {
    logic               hit;        // pixel lands in sprite and on screen
    logic               to_opaque;  // tally choice for a hit
    logic               show;       // hit and not keyed out
    logic               use_pal;    // color comes from the palette
    logic               pal_oob;    // palette index beyond the table
    logic [SLOT_W-1:0]  pal_idx;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COLOR_W-1:0] color;
  } map_t;

endpackage

FILE: src/sbcmk_cfg_regs.sv
// Configuration register file of the sprite blitter.
// Depends on sbcmk_pkg.
module sbcmk_cfg_regs
  import sbcmk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_POS_X:         cfg_nxt.pos_x         = signed'(cfg_data[POS_W-1:0]);
        CFG_POS_Y:         cfg_nxt.pos_y         = signed'(cfg_data[POS_W-1:0]);
        CFG_SPRITE_WIDTH:  cfg_nxt.sprite_width  = cfg_data[SIZE_W-1:0];
        CFG_SPRITE_HEIGHT: cfg_nxt.sprite_height = cfg_data[SIZE_W-1:0];
        CFG_MODE_BITS:     cfg_nxt.mode_bits     = cfg_data[MODE_W-1:0];
        CFG_KEY_COLOR:     cfg_nxt.key_color     = cfg_data[COLOR_W-1:0];
        CFG_FRAME_SELECT:  cfg_nxt.frame_select  = cfg_data[FRAME_W-1:0];
        CFG_FRAME_TOTAL:   cfg_nxt.frame_total   = cfg_data[FRAME_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: src/sbcmk_pal_ram.sv
// Palette memory: one write port, one registered read port.
// Contents are undefined until written. Depends on sbcmk_pkg.
module sbcmk_pal_ram
  import sbcmk_pkg::*;
#(
  parameter int PALETTE_SIZE = DEF_PALETTE_SIZE
)
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [SLOT_W-1:0]  wr_slot,
  input  logic [COLOR_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [SLOT_W-1:0]  rd_idx,
  output logic [COLOR_W-1:0] rd_data
);

  localparam int AW = $clog2(PALETTE_SIZE);

  logic [COLOR_W-1:0] mem [PALETTE_SIZE];
  logic               slot_ok;

  // writes beyond the table are dropped
  assign slot_ok = ({1'b0, wr_slot} < (SLOT_W+1)'(PALETTE_SIZE));

  always_ff @(posedge clk) begin
    if (wr_en && slot_ok) begin
      mem[wr_slot[AW-1:0]] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
  end

endmodule

FILE: src/sbcmk_map.sv
// Front end: clip, mirror, frame select and color key decision per item.
// Pure logic between the input port and the first pipeline register.
// Depends on sbcmk_pkg.
module sbcmk_map
  import sbcmk_pkg::*;
#(
  parameter int SCREEN_WIDTH    = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT   = DEF_SCREEN_HEIGHT,
  parameter int MAX_SPRITE_SIZE = DEF_MAX_SPRITE_SIZE,
  parameter int PALETTE_SIZE    = DEF_PALETTE_SIZE,
  parameter int KEY_INDEX       = DEF_KEY_INDEX
)
(
  input  cfg_t     cfg,
  input  in_item_t item,
  output map_t     map
);

  localparam logic [SIZE_W+1:0] MAX_SZ = (SIZE_W+2)'(MAX_SPRITE_SIZE);

  logic               indexed, key_on, mirror;
  logic [SIZE_W+1:0]  w_sat, h_sat;
  logic [SIZE_W-1:0]  w, h;
  logic [FRAME_W-1:0] eff_frame;
  logic               in_sprite, frame_ok, on_x, on_y, keyed;
  logic [COORD_W-1:0] off;
  logic [POS_W+1:0]   sx_full;
  logic [POS_W:0]     sy_full;
  logic [SLOT_W-1:0]  idx;

  always_comb begin
    indexed = cfg.mode_bits[MODE_INDEXED];
    key_on  = cfg.mode_bits[MODE_KEY];
    mirror  = cfg.mode_bits[MODE_MIRROR];

    // sprite size saturates at the maximum
    w_sat = ({2'b00, cfg.sprite_width} > MAX_SZ) ? MAX_SZ : {2'b00, cfg.sprite_width};
    h_sat = ({2'b00, cfg.sprite_height} > MAX_SZ) ? MAX_SZ : {2'b00, cfg.sprite_height};
    w     = w_sat[SIZE_W-1:0];
    h     = h_sat[SIZE_W-1:0];

    in_sprite = ({1'b0, item.src_col} < w) && ({1'b0, item.src_row} < h);

    // out-of-range frame select falls back to frame 0
    eff_frame = (cfg.frame_select < cfg.frame_total) ? cfg.frame_select : '0;
    frame_ok  = !indexed || (item.frame_num == eff_frame);

    // column offset, mirrored about the sprite width
    off = mirror ? (COORD_W'(w) - COORD_W'(1) - COORD_W'(item.src_col))
                 : COORD_W'(item.src_col);

    sx_full = {{2{cfg.pos_x[POS_W-1]}}, cfg.pos_x} + (POS_W+2)'(off);
    sy_full = {cfg.pos_y[POS_W-1], cfg.pos_y} + (POS_W+1)'(item.src_row);
    on_x    = !sx_full[POS_W+1] && (sx_full < (POS_W+2)'(SCREEN_WIDTH));
    on_y    = !sy_full[POS_W] && (sy_full < (POS_W+1)'(SCREEN_HEIGHT));

    idx   = item.pixel_value[SLOT_W-1:0];
    keyed = key_on && (indexed ? (idx == SLOT_W'(KEY_INDEX))
                               : (item.pixel_value == cfg.key_color));

    map.hit       = (req_t'(item.req_type) == REQ_PIXEL) && in_sprite && frame_ok
                    && on_x && on_y;
    map.to_opaque = !indexed && !mirror && !key_on;
    map.show      = map.hit && !keyed;
    map.use_pal   = indexed;
    map.pal_oob   = ({1'b0, idx} >= (SLOT_W+1)'(PALETTE_SIZE));
    map.pal_idx   = idx;
    map.sx        = sx_full[COORD_W-1:0];
    map.sy        = sy_full[COORD_W-1:0];
    map.color     = item.pixel_value;
  end

endmodule

FILE: src/sprite_blit_clip_mirror_key.sv
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_item (in_item_t)
// out_      output     out_valid/out_stall out_item (out_item_t)
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle while the input is not stalled; each accepted item passes
// through the map stage register, then the output register after the palette read.
// The palette RAM read port is hit once per pixel item at acceptance.
// Reset clears config, tallies and pipeline valids; palette contents stay
// undefined until written. A stalled output holds its item; the input
// stalls only when both pipeline slots are full and the output is stalled.
module sprite_blit_clip_mirror_key
  import sbcmk_pkg::*;
#(
  parameter int SCREEN_WIDTH    = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT   = DEF_SCREEN_HEIGHT,
  parameter int MAX_SPRITE_SIZE = DEF_MAX_SPRITE_SIZE,
  parameter int PALETTE_SIZE    = DEF_PALETTE_SIZE,
  parameter int KEY_INDEX       = DEF_KEY_INDEX
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PROD_W = 2 * COORD_W + 1;

  cfg_t               cfg;
  map_t               map;
  logic               in_acc, is_pixel;
  logic [COLOR_W-1:0] pal_data;

  logic               s1_valid_r, s1_valid_nxt;
  map_t               s1_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_free, s1_adv;
  logic [CNT_W-1:0]   opaque_r, opaque_nxt, keyed_r, keyed_nxt;
  logic [PROD_W-1:0]  addr_full;

  sbcmk_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sbcmk_map #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .MAX_SPRITE_SIZE (MAX_SPRITE_SIZE),
    .PALETTE_SIZE    (PALETTE_SIZE),
    .KEY_INDEX       (KEY_INDEX)
  ) u_map (
    .cfg  (cfg),
    .item (in_item),
    .map  (map)
  );

  // handshake: the output register frees when empty or taken
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign is_pixel  = (req_t'(in_item.req_type) == REQ_PIXEL);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // palette written and read at acceptance
  sbcmk_pal_ram #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_pal (
    .clk     (clk),
    .wr_en   (in_acc && (req_t'(in_item.req_type) == REQ_PALETTE)),
    .wr_slot (in_item.palette_slot),
    .wr_data (in_item.pixel_value),
    .rd_en   (in_acc && is_pixel),
    .rd_idx  (map.pal_idx),
    .rd_data (pal_data)
  );

  // tallies follow accepted items in order
  always_comb begin
    opaque_nxt = opaque_r;
    keyed_nxt  = keyed_r;
    if (in_acc) begin
      if (req_t'(in_item.req_type) == REQ_CLEAR) begin
        opaque_nxt = '0;
        keyed_nxt  = '0;
      end else if (map.hit) begin
        if (map.to_opaque) begin
          opaque_nxt = opaque_r + CNT_W'(1);
        end else begin
          keyed_nxt = keyed_r + CNT_W'(1);
        end
      end
    end
  end

  // map stage valid
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // output stage: address, palette select; tallies are current for this item
  always_comb begin
    addr_full     = PROD_W'(s1_r.sy) * PROD_W'(SCREEN_WIDTH) + PROD_W'(s1_r.sx);
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt         = 1'b1;
      out_nxt.write_enable  = s1_r.show;
      out_nxt.pixel_address = s1_r.show ? addr_full[ADDR_W-1:0] : '0;
      if (!s1_r.show) begin
        out_nxt.pixel_color = '0;
      end else if (s1_r.use_pal) begin
        out_nxt.pixel_color = s1_r.pal_oob ? '0 : pal_data;
      end else begin
        out_nxt.pixel_color = s1_r.color;
      end
      out_nxt.opaque_count = opaque_r;
      out_nxt.keyed_count  = keyed_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      opaque_r    <= '0;
      keyed_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      opaque_r    <= opaque_nxt;
      keyed_r     <= keyed_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= map;
    end
    out_r <= out_nxt;
  end

endmodule

FILE: src/sbcmk_checker.sv
// Port-level checks for the sprite blitter, bound to the top level.
// Depends on sbcmk_pkg and sprite_blit_clip_mirror_key.
module sbcmk_checker
  import sbcmk_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  localparam longint AREA      = longint'(SCREEN_WIDTH) * longint'(SCREEN_HEIGHT);
  localparam logic   AREA_FITS = (AREA <= (64'd1 << ADDR_W));

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  // no write means zero address and color
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.write_enable |->
      (out_item.pixel_address == '0) && (out_item.pixel_color == '0))
    else $error("dropped pixel carries address or color");

  // writes stay inside the framebuffer
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.write_enable && AREA_FITS |->
      (longint'(out_item.pixel_address) < AREA))
    else $error("write address beyond the screen");

endmodule

bind sprite_blit_clip_mirror_key sbcmk_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_sbcmk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
